FILE: hw/rtl/adc_sample_packer_12bit_core_defines.svh
// Assertion macros for the ADC sample packer.
// Included by the top level; no other dependencies.
`ifndef ADC_SAMPLE_PACKER_12BIT_CORE_DEFINES_SVH
`define ADC_SAMPLE_PACKER_12BIT_CORE_DEFINES_SVH

// same-cycle implication
`define ASP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/asp_pkg.sv
// Shared types and constants for the ADC sample packer.
// No dependencies.
package asp_pkg;

  localparam int SampleW   = 12;
  localparam int CountW    = 16;
  localparam int ByteW     = 8;
  localparam int MaxBytes  = 4;
  localparam int SlotW     = $clog2(MaxBytes);
  localparam int NumW      = $clog2(MaxBytes + 1);

  localparam logic ActStart  = 1'b0;
  localparam logic ActSample = 1'b1;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [NumW-1:0]  num_t;

  // bytes caused by one input transaction
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    slot_t                          last_idx;
    logic                           eop;
    logic                           err;
  } bundle_t;

endpackage

FILE: hw/rtl/asp_ifs.sv
// Valid/ready channel interfaces for the ADC sample packer.
// Depends on asp_pkg.
interface asp_item_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [asp_pkg::SampleW-1:0]  sample;

  modport source (output valid, action, sample, input ready);
  modport sink   (input valid, action, sample, output ready);
endinterface

interface asp_result_if;
  logic                        valid;
  logic                        ready;
  logic [asp_pkg::ByteW-1:0]   out_byte;
  logic                        last_of_run;
  logic                        end_of_packet;
  logic                        error;

  modport source (output valid, out_byte, last_of_run, end_of_packet, error, input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_packet, error, output ready);
endinterface

FILE: hw/rtl/asp_serializer.sv
// Result register: holds the bytes of one transaction and hands them out one a cycle
// while result.ready is high. Depends on asp_pkg and asp_result_if.
module asp_serializer (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  asp_pkg::bundle_t  load_data,
  output logic              free,
  asp_result_if.source      result
);

  logic             bvalid;
  asp_pkg::slot_t   idx;
  asp_pkg::bundle_t bundle;
  logic             at_last;

  assign at_last = (idx == bundle.last_idx);
  assign free    = !bvalid || (result.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      bvalid <= 1'b1;
      idx    <= '0;
    end else if (bvalid && result.ready) begin
      if (at_last) begin
        bvalid <= 1'b0;
      end else begin
        idx <= idx + asp_pkg::slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= load_data;
    end
  end

  assign result.valid         = bvalid;
  assign result.out_byte      = bundle.bytes[idx];
  assign result.last_of_run   = at_last;
  assign result.end_of_packet = bundle.eop && at_last;
  assign result.error         = bundle.err;

endmodule

FILE: hw/rtl/adc_sample_packer_12bit_core.sv
// Top level of the ADC sample packer: input register, framing logic, packet state.
// Depends on asp_pkg, asp_ifs, asp_serializer and the assertion macro header.
//
// Usage:
//   item    - sink channel. action = start (emit the 16-bit count header and open a
//             packet, or at length 0 send the checksum) or sample (one 12-bit sample).
//   result  - source channel, one packet byte per transaction, with last_of_run on
//             the final byte an item causes, end_of_packet on the checksum byte and
//             error on the single zero byte sent for a sample with no open packet.
//   sample_count_we / sample_count_wdata - write of the packet length register.
// Path: an accepted item waits in the input register, is framed combinationally and
//   is loaded into the result register once that is free, which then sends its bytes.
// Throughput: the result register sends one byte per cycle while result.ready is high;
//   an item causes 1 to 4 bytes, and a held first-of-pair sample causes none.
//   The result register is the limiting unit.
// Reset clears the packet state, the length register and both valid flags.
// When the receiver stalls, the waiting bytes hold and one more item is taken into
//   the input register; item.ready then drops until the bytes drain.
`include "adc_sample_packer_12bit_core_defines.svh"

module adc_sample_packer_12bit_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_count_we,
  input  logic [asp_pkg::CountW-1:0]  sample_count_wdata,
  asp_item_if.sink                    item,
  asp_result_if.source                result
);

  logic [asp_pkg::CountW-1:0]  sample_count;

  logic                        in_valid;
  logic                        in_action;
  logic [asp_pkg::SampleW-1:0] in_sample;

  logic                        packet_open;
  logic [asp_pkg::CountW-1:0]  samples_taken;
  logic [asp_pkg::SampleW-1:0] held_sample;
  logic [asp_pkg::ByteW-1:0]   running_sum;

  logic                        packet_open_next;
  logic [asp_pkg::CountW-1:0]  samples_taken_next;
  logic [asp_pkg::SampleW-1:0] held_sample_next;
  logic [asp_pkg::ByteW-1:0]   running_sum_next;

  asp_pkg::bundle_t            frame;
  asp_pkg::num_t               frame_num;
  logic                        free;
  logic                        move;
  logic                        load;

  assign move       = in_valid && free;
  assign load       = move && (frame_num != '0);
  assign item.ready = !in_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (sample_count_we) begin
      sample_count <= sample_count_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_action <= item.action;
      in_sample <= item.sample;
    end
  end

  always_comb begin
    logic [asp_pkg::CountW:0]  taken;
    logic                      last;
    logic [asp_pkg::ByteW-1:0] b0;
    logic [asp_pkg::ByteW-1:0] b1;
    logic [asp_pkg::ByteW-1:0] b2;
    logic [asp_pkg::ByteW-1:0] b3;

    taken = {1'b0, samples_taken} + {{asp_pkg::CountW{1'b0}}, 1'b1};
    last  = (taken >= {1'b0, sample_count});
    b0    = '0;
    b1    = '0;
    b2    = '0;
    b3    = '0;

    frame_num          = '0;
    frame.eop          = 1'b0;
    frame.err          = 1'b0;
    packet_open_next   = packet_open;
    samples_taken_next = samples_taken;
    held_sample_next   = held_sample;
    running_sum_next   = running_sum;

    if (in_action == asp_pkg::ActStart) begin
      b0                 = sample_count[15:8];
      b1                 = sample_count[7:0];
      b2                 = b0 + b1;
      frame_num          = (sample_count == '0) ? asp_pkg::num_t'(3) : asp_pkg::num_t'(2);
      frame.eop          = (sample_count == '0);
      packet_open_next   = (sample_count != '0);
      samples_taken_next = '0;
      held_sample_next   = '0;
      running_sum_next   = b0 + b1;
    end else if (!packet_open) begin
      frame_num = asp_pkg::num_t'(1);
      frame.err = 1'b1;
    end else begin
      if (!samples_taken[0]) begin
        if (last) begin
          b0        = {4'h0, in_sample[11:8]};
          b1        = in_sample[7:0];
          b2        = running_sum + b0 + b1;
          frame_num = asp_pkg::num_t'(3);
          frame.eop = 1'b1;
        end else begin
          held_sample_next = in_sample;
        end
      end else begin
        b0               = {held_sample[11:8], in_sample[11:8]};
        b1               = held_sample[7:0];
        b2               = in_sample[7:0];
        running_sum_next = running_sum + b0 + b1 + b2;
        b3               = running_sum_next;
        frame_num        = last ? asp_pkg::num_t'(4) : asp_pkg::num_t'(3);
        frame.eop        = last;
      end
      samples_taken_next = taken[asp_pkg::CountW-1:0];
      packet_open_next   = !last;
    end

    frame.bytes    = {b3, b2, b1, b0};
    frame.last_idx = asp_pkg::slot_t'(frame_num - asp_pkg::num_t'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open   <= 1'b0;
      samples_taken <= '0;
      held_sample   <= '0;
      running_sum   <= '0;
    end else if (move) begin
      packet_open   <= packet_open_next;
      samples_taken <= samples_taken_next;
      held_sample   <= held_sample_next;
      running_sum   <= running_sum_next;
    end
  end

  asp_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_data (frame),
    .free      (free),
    .result    (result)
  );

  `ASP_ASSERT_NOW(a_error_byte_shape, clk, rst, result.valid && result.error,
    result.out_byte == '0 && result.last_of_run && !result.end_of_packet)

  `ASP_ASSERT_NOW(a_checksum_closes, clk, rst,
    result.valid && result.ready && result.end_of_packet, !packet_open)

  `ASP_ASSERT_NEXT(a_held_is_first_of_pair, clk, rst, move && frame_num == '0,
    samples_taken[0] && packet_open)

  `ASP_ASSERT_NOW(a_no_drop_on_stall, clk, rst, in_valid && !free, !item.ready)

endmodule

FILE: tb/asp_stream_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ADC sample packer: watches the item, result and length-write ports,
// predicts the packet byte stream and compares every result transaction against it.
// Depends on asp_pkg.
module asp_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [asp_pkg::CountW-1:0]  cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_action,
  input  logic [asp_pkg::SampleW-1:0] in_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [asp_pkg::ByteW-1:0]   out_byte,
  input  logic                        out_last,
  input  logic                        out_eop,
  input  logic                        out_err,
  output int                          pending,
  output int                          fails
);

  typedef struct packed {
    logic [asp_pkg::ByteW-1:0] data;
    logic                      last;
    logic                      eop;
    logic                      err;
  } pkt_byte_t;

  pkt_byte_t                   expected_bytes[$];
  pkt_byte_t                   run_buf [asp_pkg::MaxBytes];
  int                          run_len;
  int                          fail_cnt = 0;
  logic [asp_pkg::CountW-1:0]  count_reg;
  logic [asp_pkg::CountW-1:0]  taken_cnt;
  logic                        pkt_open;
  logic [asp_pkg::SampleW-1:0] held;
  logic [asp_pkg::ByteW-1:0]   csum;

  task automatic put_byte(input logic [asp_pkg::ByteW-1:0] b, input logic eop);
    run_buf[run_len] = '{data: b, last: 1'b0, eop: eop, err: 1'b0};
    run_len++;
    csum = csum + b;
  endtask

  task automatic close_packet();
    put_byte(csum, 1'b1);
    pkt_open = 1'b0;
  endtask

  task automatic frame_item(input logic act, input logic [asp_pkg::SampleW-1:0] smp);
    logic closes;
    run_len = 0;
    if (act == asp_pkg::ActStart) begin
      pkt_open  = 1'b1;
      taken_cnt = '0;
      held      = '0;
      csum      = '0;
      put_byte(count_reg[15:8], 1'b0);
      put_byte(count_reg[7:0], 1'b0);
      if (count_reg == '0) close_packet();
    end else if (!pkt_open) begin
      run_buf[0] = '{data: '0, last: 1'b0, eop: 1'b0, err: 1'b1};
      run_len = 1;
    end else begin
      // count may have been lowered below what was already taken
      closes = (int'(taken_cnt) + 1) >= int'(count_reg);
      if (!taken_cnt[0]) begin
        if (closes) begin
          put_byte({4'h0, smp[11:8]}, 1'b0);
          put_byte(smp[7:0], 1'b0);
        end else begin
          held = smp;
        end
      end else begin
        put_byte({held[11:8], smp[11:8]}, 1'b0);
        put_byte(held[7:0], 1'b0);
        put_byte(smp[7:0], 1'b0);
      end
      taken_cnt = taken_cnt + 1'b1;
      if (closes) close_packet();
    end
    if (run_len > 0) run_buf[run_len-1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_bytes.push_back(run_buf[i]);
  endtask

  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst) begin
      count_reg = '0;
      taken_cnt = '0;
      pkt_open  = 1'b0;
      held      = '0;
      csum      = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      if (in_valid && in_ready) frame_item(in_action, in_sample);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected transaction byte %h last %b eop %b err %b",
                     $realtime, out_byte, out_last, out_eop, out_err);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte || want.last !== out_last ||
              want.eop !== out_eop || want.err !== out_err) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: byte differs: exp %h/%b/%b/%b got %h/%b/%b/%b (byte/last/eop/err)",
                       $realtime, want.data, want.last, want.eop, want.err,
                       out_byte, out_last, out_eop, out_err);
          end
        end
      end
    end
    pending <= expected_bytes.size();
    fails   <= fail_cnt;
  end

endmodule

FILE: tb/adc_sample_packer_12bit_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ADC sample packer: clock, reset, item and length-write stimulus,
// receiver stalls, watchdog and verdict. Depends on asp_pkg, asp_ifs and asp_stream_checker.
module adc_sample_packer_12bit_core_tb;

  localparam int WatchdogLimit = 1000;
  localparam int TotalItems    = 480;
  localparam int CalmFrom      = 420;

  logic                       clk;
  logic                       rst;
  logic                       count_we;
  logic [asp_pkg::CountW-1:0] count_wdata;
  int                         pending;
  int                         fails;
  int                         items_sent = 0;
  int                         quiet_cycles = 0;
  bit                         idle_on = 1'b1;

  asp_item_if   item_ch ();
  asp_result_if result_ch ();

  adc_sample_packer_12bit_core dut (
    .clk                (clk),
    .rst                (rst),
    .sample_count_we    (count_we),
    .sample_count_wdata (count_wdata),
    .item               (item_ch),
    .result             (result_ch)
  );

  asp_stream_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (count_we),
    .cfg_wdata (count_wdata),
    .in_valid  (item_ch.valid),
    .in_ready  (item_ch.ready),
    .in_action (item_ch.action),
    .in_sample (item_ch.sample),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_byte  (result_ch.out_byte),
    .out_last  (result_ch.last_of_run),
    .out_eop   (result_ch.end_of_packet),
    .out_err   (result_ch.error),
    .pending   (pending),
    .fails     (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall > 0) begin
        stall--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        count_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("adc_sample_packer_12bit_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic [asp_pkg::SampleW-1:0] smp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.action <= act;
    item_ch.sample <= smp;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    if (items_sent >= CalmFrom) idle_on = 1'b0;
  endtask

  task automatic send_sample();
    send_item(asp_pkg::ActSample, asp_pkg::SampleW'($urandom_range(0, 4095)));
  endtask

  task automatic send_packet(input int n);
    send_item(asp_pkg::ActStart, asp_pkg::SampleW'($urandom_range(0, 4095)));
    repeat (n) send_sample();
  endtask

  // hold off until every predicted byte has drained and the pipeline is empty
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [asp_pkg::CountW-1:0] v);
    wait_drained();
    count_we    <= 1'b1;
    count_wdata <= v;
    @(posedge clk);
    count_we    <= 1'b0;
  endtask

  initial begin
    int cur;
    int sel;
    int k;
    item_ch.valid  = 1'b0;
    item_ch.action = asp_pkg::ActStart;
    item_ch.sample = '0;
    count_we       = 1'b0;
    count_wdata    = '0;
    rst            = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no open packet, empty packet, odd tail, overrun, abandon, lowered count
    write_count(16'd0);
    send_item(asp_pkg::ActSample, 12'hFFF);
    send_item(asp_pkg::ActStart, 12'h000);
    write_count(16'd3);
    send_item(asp_pkg::ActStart, 12'hFFF);
    send_item(asp_pkg::ActSample, 12'hFFF);
    send_item(asp_pkg::ActSample, 12'h000);
    send_item(asp_pkg::ActSample, 12'hABC);
    write_count(16'd2);
    send_item(asp_pkg::ActStart, 12'h555);
    send_item(asp_pkg::ActSample, 12'h000);
    send_item(asp_pkg::ActSample, 12'hFFF);
    send_item(asp_pkg::ActSample, 12'h3C3);
    write_count(16'hFFFF);
    send_item(asp_pkg::ActStart, 12'hAAA);
    send_item(asp_pkg::ActSample, 12'h123);
    send_item(asp_pkg::ActSample, 12'h456);
    send_item(asp_pkg::ActSample, 12'hFED);
    write_count(16'd2);
    send_item(asp_pkg::ActSample, 12'h0F0);
    write_count(16'd5);
    send_item(asp_pkg::ActStart, 12'h000);
    send_item(asp_pkg::ActSample, 12'h801);
    send_item(asp_pkg::ActSample, 12'h7FE);
    send_item(asp_pkg::ActStart, 12'h000);
    write_count(16'd1);
    send_item(asp_pkg::ActSample, 12'hC35);
    send_item(asp_pkg::ActStart, 12'h000);
    send_item(asp_pkg::ActSample, 12'h5A5);
    send_item(asp_pkg::ActSample, 12'hA5A);

    while (items_sent < TotalItems) begin
      sel = $urandom_range(0, 15);
      if (sel == 0)      cur = 65535;
      else if (sel == 1) cur = $urandom_range(0, 65535);
      else if (sel == 2) cur = 0;
      else               cur = $urandom_range(1, 9);
      write_count(asp_pkg::CountW'(cur));
      repeat ($urandom_range(1, 4)) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          send_packet((cur <= 12) ? cur : $urandom_range(0, 12));
        end else if (sel == 7) begin
          repeat ($urandom_range(1, 4))
            send_item(logic'($urandom_range(0, 1)),
                      asp_pkg::SampleW'($urandom_range(0, 4095)));
        end else if (sel == 8) begin
          send_packet($urandom_range(0, (cur + 2 < 14) ? cur + 2 : 14));
        end else begin
          send_packet((cur <= 12) ? cur : $urandom_range(0, 12));
          wait_drained();
        end
      end
      if (cur >= 3 && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, (cur - 1 < 10) ? cur - 1 : 10);
        send_packet(k);
        write_count(asp_pkg::CountW'($urandom_range(0, k)));
        repeat ($urandom_range(1, 2)) send_sample();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("adc_sample_packer_12bit_core: match");
    end else begin
      $display("adc_sample_packer_12bit_core: mismatch");
    end
    $finish;
  end

endmodule
